[rtl/hsfc_pkg.sv]
// ----------------------------------------------------------------------------
// hsfc_pkg
// Shared constants for the binary32 / binary16 converter.
// ----------------------------------------------------------------------------
package hsfc_pkg;

  // conversion direction carried by each transaction
  typedef enum logic {
    ACT_TO_HALF   = 1'b0,
    ACT_TO_SINGLE = 1'b1
  } action_e;

  // binary16 field constants
  localparam logic [15:0] HalfQnan    = 16'h7E00;
  localparam logic [15:0] HalfInf     = 16'h7C00;
  localparam logic [4:0]  HalfExpMax  = 5'd31;

  // binary32 field constants
  localparam logic [31:0] SingleInf   = 32'h7F80_0000;
  localparam logic [7:0]  SingleExpMax = 8'd255;

  // exponent rebias between the formats (127 - 15)
  localparam logic [7:0]  Rebias      = 8'd112;
  // first single exponent that overflows a half (31 + 112)
  localparam logic [7:0]  OvfExp      = 8'd143;
  // lowest single exponent whose value can round to a nonzero half subnormal
  localparam logic [7:0]  MinSubExp   = 8'd102;
  // subnormal right shift is SubShiftBase - exponent
  localparam logic [7:0]  SubShiftBase = 8'd126;
  // single exponent of a half subnormal with its leading one at bit 0
  localparam logic [7:0]  SubExpBase  = 8'd103;

endpackage

[rtl/hsfc_if.sv]
// ----------------------------------------------------------------------------
// hsfc interfaces
// Valid/ready channels for the converter's input and result transactions.
// ----------------------------------------------------------------------------

// input channel: one conversion request per transaction
interface hsfc_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] single_bits;
  logic [15:0] half_bits;

  modport source (output valid, output action, output single_bits, output half_bits,
                  input ready);
  modport sink   (input valid, input action, input single_bits, input half_bits,
                  output ready);
endinterface

// result channel: one converted value per transaction
interface hsfc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] half_result;
  logic [31:0] single_result;

  modport source (output valid, output half_result, output single_result,
                  input ready);
  modport sink   (input valid, input half_result, input single_result,
                  output ready);
endinterface

[rtl/half_single_float_converter.sv]
// ----------------------------------------------------------------------------
// half_single_float_converter
// Stages: input register, conversion logic, result register.
// Throughput: one transaction per cycle while the result side is ready; the
//   input side keeps accepting while a finished result waits, until both
//   register stages are full.
// Reset: rst_ni clears both stage valid flags; no other state.
// ----------------------------------------------------------------------------
module half_single_float_converter
  import hsfc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  hsfc_in_if.sink      in_ch,
  hsfc_out_if.source   out_ch
);

  logic        s1_valid_q;
  logic        s1_action_q;
  logic [31:0] s1_single_q;
  logic [15:0] s1_half_q;
  logic        s2_valid_q;
  logic [15:0] s2_half_q;
  logic [31:0] s2_single_q;
  logic        s2_ready;
  logic        s1_ready;
  logic [15:0] half_w;
  logic [31:0] single_w;

  // stage handshakes
  assign s2_ready = !s2_valid_q || out_ch.ready;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign in_ch.ready = s1_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_ch.valid) begin
      s1_action_q <= in_ch.action;
      s1_single_q <= in_ch.single_bits;
      s1_half_q   <= in_ch.half_bits;
    end
  end

  // conversion units
  hsfc_to_half u_to_half (
    .single_i (s1_single_q),
    .half_o   (half_w)
  );

  hsfc_to_single u_to_single (
    .half_i   (s1_half_q),
    .single_o (single_w)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      if (action_e'(s1_action_q) == ACT_TO_SINGLE) begin
        s2_half_q   <= 16'd0;
        s2_single_q <= single_w;
      end else begin
        s2_half_q   <= half_w;
        s2_single_q <= 32'd0;
      end
    end
  end

  assign out_ch.valid         = s2_valid_q;
  assign out_ch.half_result   = s2_half_q;
  assign out_ch.single_result = s2_single_q;

endmodule

[rtl/hsfc_to_half.sv]
// ----------------------------------------------------------------------------
// hsfc_to_half
// binary32 to binary16 conversion, round to nearest even, combinational.
// ----------------------------------------------------------------------------
module hsfc_to_half
  import hsfc_pkg::*;
(
  input  logic [31:0] single_i,
  output logic [15:0] half_o
);

  logic [15:0] sign;
  logic [7:0]  ex;
  logic [22:0] man;
  logic [7:0]  he;
  logic [14:0] nq;
  logic [12:0] nrem;
  logic        nup;
  logic [14:0] nrnd;
  logic [23:0] sig;
  logic [7:0]  shift_w;
  logic [4:0]  shift;
  logic [47:0] shifted;
  logic [23:0] sq;
  logic        guard;
  logic        sticky;
  logic [10:0] srnd;

  assign sign = {single_i[31], 15'd0};
  assign ex   = single_i[30:23];
  assign man  = single_i[22:0];
  assign he   = ex - Rebias;

  // normal half result: truncate 13 bits and round to nearest even
  assign nq   = {he[4:0], man[22:13]};
  assign nrem = man[12:0];
  assign nup  = (nrem > 13'h1000) || ((nrem == 13'h1000) && nq[0]);
  assign nrnd = nq + {14'd0, nup};

  // subnormal half result: align the significand and round
  assign sig     = {1'b1, man};
  assign shift_w = SubShiftBase - ex;
  assign shift   = shift_w[4:0];
  assign shifted = {sig, 24'd0} >> shift;
  assign sq      = shifted[47:24];
  assign guard   = shifted[23];
  assign sticky  = |shifted[22:0];
  assign srnd    = sq[10:0] + {10'd0, guard & (sticky | sq[0])};

  // select by exponent class
  always_comb begin
    if (ex == SingleExpMax) begin
      if (man != 23'd0) begin
        half_o = sign | HalfQnan | {6'd0, man[22:13]};
      end else begin
        half_o = sign | HalfInf;
      end
    end else if (ex == 8'd0) begin
      half_o = sign;
    end else if (ex >= OvfExp) begin
      half_o = sign | HalfInf;
    end else if (ex > Rebias) begin
      half_o = sign | {1'b0, nrnd};
    end else if (ex < MinSubExp) begin
      half_o = sign;
    end else begin
      half_o = sign | {5'd0, srnd};
    end
  end

endmodule

[rtl/hsfc_to_single.sv]
// ----------------------------------------------------------------------------
// hsfc_to_single
// binary16 to binary32 conversion, exact, with subnormal normalization.
// ----------------------------------------------------------------------------
module hsfc_to_single
  import hsfc_pkg::*;
(
  input  logic [15:0] half_i,
  output logic [31:0] single_o
);

  logic [31:0] sign;
  logic [4:0]  ex;
  logic [9:0]  man;
  logic [3:0]  lead;
  logic [3:0]  lsh;
  logic [9:0]  nman;
  logic [7:0]  sub_exp;
  logic [7:0]  norm_exp;

  assign sign = {half_i[15], 31'd0};
  assign ex   = half_i[14:10];
  assign man  = half_i[9:0];

  // position of the leading one of a subnormal mantissa
  always_comb begin
    lead = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (man[i]) begin
        lead = i[3:0];
      end
    end
  end

  // shift the leading one out and fix the exponent
  assign lsh      = 4'd10 - lead;
  assign nman     = man << lsh;
  assign sub_exp  = SubExpBase + {4'd0, lead};
  assign norm_exp = {3'd0, ex} + Rebias;

  always_comb begin
    if (ex == HalfExpMax) begin
      single_o = sign | SingleInf | {9'd0, man, 13'd0};
    end else if (ex == 5'd0) begin
      if (man == 10'd0) begin
        single_o = sign;
      end else begin
        single_o = sign | {1'b0, sub_exp, nman, 13'd0};
      end
    end else begin
      single_o = sign | {1'b0, norm_exp, man, 13'd0};
    end
  end

endmodule

[rtl/hsfc_checker.sv]
// ----------------------------------------------------------------------------
// hsfc_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] half_result_i,
  input logic [31:0] single_result_i
);

  // no result is shown while reset is held
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  // input only backs up when the result side is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("input stalled without output backpressure");

  // a result carries at most one direction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_i |-> ((half_result_i == 16'd0) || (single_result_i == 32'd0)))
    else $error("both result fields nonzero");

  // a stalled result transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_i && !out_ready_i) |=>
        (out_valid_i && $stable(half_result_i) && $stable(single_result_i)))
    else $error("stalled result changed");

  // accepted input with a free result side shows a result after the input stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (in_valid_i && in_ready_i && !out_valid_i) |=> ##1 out_valid_i)
    else $error("result missing after accepted transaction");

endmodule

bind half_single_float_converter hsfc_checker u_hsfc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_ch.valid),
  .in_ready_i      (in_ch.ready),
  .out_valid_i     (out_ch.valid),
  .out_ready_i     (out_ch.ready),
  .half_result_i   (out_ch.half_result),
  .single_result_i (out_ch.single_result)
);
